// File: design/dkac_pkg.sv
package dkac_pkg;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_ACUTE,
    ACC_GRAVE,
    ACC_CIRC,
    ACC_DIAER
  } accent_e;

  // One queue entry: the one or two code points caused by one input byte.
  typedef struct packed {
    logic        two;
    logic [20:0] cp0;
    logic [20:0] cp1;
    logic        eot;
  } job_t;

  // Head of the queue as seen by the output side.
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  localparam logic [20:0] CP_ACUTE = 21'h0000B4;
  localparam logic [20:0] CP_GRAVE = 21'h000060;
  localparam logic [20:0] CP_CIRC  = 21'h00005E;
  localparam logic [20:0] CP_DIAER = 21'h0000A8;

  localparam logic [2:0] VOWEL_NONE = 3'd7;

  // Composed characters by accent and vowel a e i o u y; zero where none exists.
  localparam logic [7:0] LOWER_TAB [5][6] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA, 8'hFD},
    '{8'hE0, 8'hE8, 8'hEC, 8'hF2, 8'hF9, 8'h00},
    '{8'hE2, 8'hEA, 8'hEE, 8'hF4, 8'hFB, 8'h00},
    '{8'hE4, 8'hEB, 8'hEF, 8'hF6, 8'hFC, 8'hFF}
  };
  localparam logic [7:0] UPPER_TAB [5][6] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hC1, 8'hC9, 8'hCD, 8'hD3, 8'hDA, 8'hDD},
    '{8'hC0, 8'hC8, 8'hCC, 8'hD2, 8'hD9, 8'h00},
    '{8'hC2, 8'hCA, 8'hCE, 8'hD4, 8'hDB, 8'h00},
    '{8'hC4, 8'hCB, 8'hCF, 8'hD6, 8'hDC, 8'h00}
  };

  function automatic logic [20:0] accent_cp(accent_e acc);
    logic [20:0] cp;
    case (acc)
      ACC_ACUTE: cp = CP_ACUTE;
      ACC_GRAVE: cp = CP_GRAVE;
      ACC_CIRC:  cp = CP_CIRC;
      ACC_DIAER: cp = CP_DIAER;
      default:   cp = '0;
    endcase
    return cp;
  endfunction

  function automatic accent_e accent_of(logic [20:0] cp);
    accent_e acc;
    case (cp)
      CP_ACUTE: acc = ACC_ACUTE;
      CP_GRAVE: acc = ACC_GRAVE;
      CP_CIRC:  acc = ACC_CIRC;
      CP_DIAER: acc = ACC_DIAER;
      default:  acc = ACC_NONE;
    endcase
    return acc;
  endfunction

  function automatic logic [2:0] vowel_index(logic [6:0] lc);
    logic [2:0] v;
    case (lc)
      7'h61:   v = 3'd0;
      7'h65:   v = 3'd1;
      7'h69:   v = 3'd2;
      7'h6F:   v = 3'd3;
      7'h75:   v = 3'd4;
      7'h79:   v = 3'd5;
      default: v = VOWEL_NONE;
    endcase
    return v;
  endfunction

  // Returns zero when the pair does not compose.
  function automatic logic [7:0] compose(accent_e acc, logic [20:0] cp);
    logic       is_lower;
    logic       is_upper;
    logic [2:0] v;
    logic [7:0] res;
    is_lower = cp inside {[21'h61:21'h7A]};
    is_upper = cp inside {[21'h41:21'h5A]};
    v        = vowel_index(cp[6:0] | 7'h20);
    res      = '0;
    if ((acc != ACC_NONE) && (acc <= ACC_DIAER) && (v != VOWEL_NONE)) begin
      if (is_lower) begin
        res = LOWER_TAB[acc][v];
      end else if (is_upper) begin
        res = UPPER_TAB[acc][v];
      end
    end
    return res;
  endfunction

endpackage

// File: design/dead_key_accent_composer_unit.sv
// Channel   Direction   Handshake                 Payload
// in        input       in_valid_i / in_stall_o   text_byte_i, end_of_text_i
// out       output      out_valid_o / out_stall_i code_point_o, last_of_run_o, text_done_o
//
// One byte is taken per cycle unless the queue is full; a byte that yields two code points
// holds the output register for both, so the sustained rate is one code point per cycle unless stalled.
// A result passes through the queue write and then the output register. The input stalls only
// while the two-entry queue is full. Reset clears the decoder state, the queue pointers and count,
// and the output valid flag at once; the output data registers are not reset.
module dead_key_accent_composer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        last_of_run_o,
  output logic        text_done_o
);

  logic            push;
  logic            full;
  logic            pop;
  dkac_pkg::job_t  job;
  dkac_pkg::head_t head;

  assign in_stall_o = full;

  dkac_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (full),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .job_o         (job)
  );

  dkac_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  dkac_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .last_of_run_o (last_of_run_o),
    .text_done_o   (text_done_o)
  );

endmodule

// File: design/dkac_front.sv
module dkac_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  logic [7:0]     text_byte_i,
  input  logic           end_of_text_i,
  output logic           push_o,
  output dkac_pkg::job_t job_o
);

  dkac_pkg::accent_e pend_q, pend_d;
  logic [20:0]       part_q, part_d;
  logic [1:0]        rem_q, rem_d;

  logic              take;
  logic              char_valid;
  logic [20:0]       char_cp;
  logic [20:0]       cont_part;
  logic [7:0]        comp;
  dkac_pkg::accent_e char_acc;
  logic [1:0]        cnt;
  logic [20:0]       e0, e1;

  assign take      = in_valid_i && !in_stall_i;
  assign cont_part = {part_q[14:0], text_byte_i[5:0]};

  // Byte decoding.
  always_comb begin
    char_valid = 1'b0;
    char_cp    = '0;
    part_d     = '0;
    rem_d      = '0;
    if ((rem_q != 2'd0) && (text_byte_i[7:6] == 2'b10)) begin
      rem_d = rem_q - 2'd1;
      if (rem_q == 2'd1) begin
        char_valid = 1'b1;
        char_cp    = cont_part;
      end else begin
        part_d = cont_part;
      end
    end else if (text_byte_i < 8'h80) begin
      char_valid = 1'b1;
      char_cp    = {13'd0, text_byte_i};
    end else if (text_byte_i inside {[8'hC0:8'hDF]}) begin
      part_d = {16'd0, text_byte_i[4:0]};
      rem_d  = 2'd1;
    end else if (text_byte_i inside {[8'hE0:8'hEF]}) begin
      part_d = {17'd0, text_byte_i[3:0]};
      rem_d  = 2'd2;
    end else if (text_byte_i inside {[8'hF0:8'hF7]}) begin
      part_d = {18'd0, text_byte_i[2:0]};
      rem_d  = 2'd3;
    end else begin
      // A stray continuation byte or an invalid lead passes through as itself.
      char_valid = 1'b1;
      char_cp    = {13'd0, text_byte_i};
    end
    if (end_of_text_i) begin
      part_d = '0;
      rem_d  = '0;
    end
  end

  assign comp     = dkac_pkg::compose(pend_q, char_cp);
  assign char_acc = dkac_pkg::accent_of(char_cp);

  // Dead key handling; at most two code points come out per byte.
  always_comb begin
    pend_d = pend_q;
    cnt    = 2'd0;
    e0     = '0;
    e1     = '0;
    if (char_valid) begin
      if ((pend_q != dkac_pkg::ACC_NONE) && (comp != 8'd0)) begin
        e0     = {13'd0, comp};
        cnt    = 2'd1;
        pend_d = dkac_pkg::ACC_NONE;
      end else begin
        if (pend_q != dkac_pkg::ACC_NONE) begin
          e0  = dkac_pkg::accent_cp(pend_q);
          cnt = 2'd1;
        end
        pend_d = char_acc;
        if (char_acc == dkac_pkg::ACC_NONE) begin
          if (cnt == 2'd0) begin
            e0 = char_cp;
          end else begin
            e1 = char_cp;
          end
          cnt = cnt + 2'd1;
        end
      end
    end
    if (end_of_text_i) begin
      if (pend_d != dkac_pkg::ACC_NONE) begin
        if (cnt == 2'd0) begin
          e0 = dkac_pkg::accent_cp(pend_d);
        end else begin
          e1 = dkac_pkg::accent_cp(pend_d);
        end
        cnt = cnt + 2'd1;
      end
      pend_d = dkac_pkg::ACC_NONE;
    end
  end

  assign push_o    = take && (cnt != 2'd0);
  assign job_o.two = (cnt == 2'd2);
  assign job_o.cp0 = e0;
  assign job_o.cp1 = e1;
  assign job_o.eot = end_of_text_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= dkac_pkg::ACC_NONE;
      part_q <= '0;
      rem_q  <= '0;
    end else if (take) begin
      pend_q <= pend_d;
      part_q <= part_d;
      rem_q  <= rem_d;
    end
  end

endmodule

// File: design/dkac_queue.sv
module dkac_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dkac_pkg::job_t  job_i,
  output logic            full_o,
  input  logic            pop_i,
  output dkac_pkg::head_t head_o
);

  dkac_pkg::job_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.job   = mem_q[rd_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
    end
  end

endmodule

// File: design/dkac_back.sv
module dkac_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dkac_pkg::head_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [20:0]     code_point_o,
  output logic            last_of_run_o,
  output logic            text_done_o
);

  logic        valid_q;
  logic        phase_q, phase_d;
  logic [20:0] cp_q;
  logic        last_q, last_d;
  logic        done_q;
  logic        load;

  // The output register reloads whenever it is empty or its transfer completes.
  assign load   = !valid_q || !out_stall_i;
  assign last_d = !head_i.job.two || phase_q;
  assign pop_o  = load && head_i.valid && last_d;

  always_comb begin
    phase_d = phase_q;
    if (load && head_i.valid) begin
      phase_d = !last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_i.valid) begin
      cp_q   <= phase_q ? head_i.job.cp1 : head_i.job.cp0;
      last_q <= last_d;
      done_q <= head_i.job.eot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        valid_q <= head_i.valid;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign code_point_o  = cp_q;
  assign last_of_run_o = last_q;
  assign text_done_o   = done_q;

endmodule

// File: dv/dead_key_accent_composer_checker.sv
`timescale 1ns / 1ps

module dead_key_accent_composer_checker
  import dkac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [20:0] code_point_i,
  input  logic        last_of_run_i,
  input  logic        text_done_i,
  output int          fail_count_o,
  output int          chars_outstanding_o
);

  typedef struct packed {
    logic [20:0] code_point;
    logic        last_of_run;
    logic        text_done;
  } decoded_char_t;

  localparam logic [20:0] ACCENT_CHAR [5] = '{21'h0, CP_ACUTE, CP_GRAVE, CP_CIRC, CP_DIAER};
  localparam logic [8*6-1:0] VOWEL_ORDER = "yuoiea";

  localparam logic [7:0] LOWER_ACCENTED [5][6] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA, 8'hFD},
    '{8'hE0, 8'hE8, 8'hEC, 8'hF2, 8'hF9, 8'h00},
    '{8'hE2, 8'hEA, 8'hEE, 8'hF4, 8'hFB, 8'h00},
    '{8'hE4, 8'hEB, 8'hEF, 8'hF6, 8'hFC, 8'hFF}
  };
  localparam logic [7:0] UPPER_ACCENTED [5][6] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hC1, 8'hC9, 8'hCD, 8'hD3, 8'hDA, 8'hDD},
    '{8'hC0, 8'hC8, 8'hCC, 8'hD2, 8'hD9, 8'h00},
    '{8'hC2, 8'hCA, 8'hCE, 8'hD4, 8'hDB, 8'h00},
    '{8'hC4, 8'hCB, 8'hCF, 8'hD6, 8'hDC, 8'h00}
  };

  accent_e       held_accent;
  logic [20:0]   gathered_bits;
  logic [1:0]    cont_left;
  logic [20:0]   step_chars [2];
  int            step_count;
  int            mismatch_count;
  decoded_char_t expected_chars [$];

  // Zero means the accent and the character do not merge.
  function automatic logic [20:0] composed_char(accent_e acc, logic [20:0] cp);
    logic       upper;
    logic [7:0] folded;
    int         slot;
    upper = (cp >= 21'h41) && (cp <= 21'h5A);
    slot  = -1;
    if (acc == ACC_NONE) return '0;
    if (upper) begin
      folded = cp[7:0] | 8'h20;
    end else if ((cp >= 21'h61) && (cp <= 21'h7A)) begin
      folded = cp[7:0];
    end else begin
      return '0;
    end
    for (int k = 0; k < 6; k++) begin
      if (VOWEL_ORDER[8*k +: 8] == folded) slot = k;
    end
    if (slot < 0) return '0;
    return upper ? {13'h0, UPPER_ACCENTED[int'(acc)][slot]}
                 : {13'h0, LOWER_ACCENTED[int'(acc)][slot]};
  endfunction

  function automatic accent_e dead_key_of(logic [20:0] cp);
    for (int k = 1; k < 5; k++) begin
      if (ACCENT_CHAR[k] == cp) return accent_e'(k);
    end
    return ACC_NONE;
  endfunction

  task automatic emit_char(input logic [20:0] cp);
    if (step_count < 2) begin
      step_chars[step_count] = cp;
      step_count++;
    end
  endtask

  task automatic take_char(input logic [20:0] cp);
    logic [20:0] merged;
    accent_e     acc;
    if (held_accent != ACC_NONE) begin
      merged = composed_char(held_accent, cp);
      if (merged != '0) begin
        held_accent = ACC_NONE;
        emit_char(merged);
        return;
      end
      emit_char(ACCENT_CHAR[int'(held_accent)]);
      held_accent = ACC_NONE;
    end
    acc = dead_key_of(cp);
    if (acc != ACC_NONE) begin
      held_accent = acc;
    end else begin
      emit_char(cp);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    decoded_char_t entry;
    step_count = 0;
    if ((cont_left != 2'd0) && (b[7:6] == 2'b10)) begin
      gathered_bits = {gathered_bits[14:0], b[5:0]};
      cont_left     = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        take_char(gathered_bits);
        gathered_bits = '0;
      end
    end else begin
      // A byte that breaks a sequence drops the partial character first.
      cont_left     = 2'd0;
      gathered_bits = '0;
      if (b[7] == 1'b0) begin
        take_char({13'h0, b});
      end else if (b[7:5] == 3'b110) begin
        gathered_bits = {16'h0, b[4:0]};
        cont_left     = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        gathered_bits = {17'h0, b[3:0]};
        cont_left     = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        gathered_bits = {18'h0, b[2:0]};
        cont_left     = 2'd3;
      end else begin
        take_char({13'h0, b});
      end
    end
    if (eot) begin
      if (held_accent != ACC_NONE) emit_char(ACCENT_CHAR[int'(held_accent)]);
      held_accent   = ACC_NONE;
      gathered_bits = '0;
      cont_left     = 2'd0;
    end
    for (int k = 0; k < step_count; k++) begin
      entry.code_point  = step_chars[k];
      entry.last_of_run = (k == step_count - 1);
      entry.text_done   = eot;
      expected_chars.push_back(entry);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_char_t want;
    if (!rst_ni) begin
      held_accent    = ACC_NONE;
      gathered_bits  = '0;
      cont_left      = 2'd0;
      mismatch_count = 0;
      expected_chars.delete();
      fail_count_o        <= 0;
      chars_outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected code point %h last=%b done=%b at %0t",
                     code_point_i, last_of_run_i, text_done_i, $realtime);
          end
        end else begin
          want = expected_chars.pop_front();
          if ((want.code_point != code_point_i) || (want.last_of_run != last_of_run_i) ||
              (want.text_done != text_done_i)) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch at %0t: expected cp=%h last=%b done=%b, got cp=%h last=%b done=%b",
                       $realtime, want.code_point, want.last_of_run, want.text_done,
                       code_point_i, last_of_run_i, text_done_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(text_byte_i, end_of_text_i);
      end
      fail_count_o        <= mismatch_count;
      chars_outstanding_o <= expected_chars.size();
    end
  end

endmodule

// File: dv/dead_key_accent_composer_unit_tb.sv
`timescale 1ns / 1ps

module dead_key_accent_composer_unit_tb;
  import dkac_pkg::*;

  localparam int RANDOM_BYTES = 700;
  localparam int HOLD_CYCLES  = 64;
  localparam logic [8*12-1:0] VOWEL_TEXT = "aeiouyAEIOUY";

  // Opening text: {end_of_text, byte}.
  localparam logic [8:0] OPENING_TEXT [23] = '{
    9'h000, 9'h0FF,                 // zero byte, invalid lead at the top
    9'h0C2, 9'h0B4, 9'h061,         // acute then a
    9'h060, 9'h049,                 // grave then capital I
    9'h05E, 9'h05E, 9'h065,         // circumflex twice, then e
    9'h0C2, 9'h0A8, 9'h059,         // diaeresis then capital Y, which does not merge
    9'h080,                         // stray continuation byte
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, // largest four-byte character
    9'h0E0, 9'h061,                 // broken sequence
    9'h160,                         // grave at end of text comes out plainly
    9'h0F0, 9'h190                  // unfinished sequence at end of text is dropped
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  text_byte;
  logic        end_of_text;
  logic        out_valid;
  logic        out_stall;
  logic [20:0] code_point;
  logic        last_of_run;
  logic        text_done;
  int          fail_count;
  int          chars_outstanding;
  logic        hold_req;
  logic        quiet;
  int          bytes_sent;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dead_key_accent_composer_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .text_byte_i   (text_byte),
    .end_of_text_i (end_of_text),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .code_point_o  (code_point),
    .last_of_run_o (last_of_run),
    .text_done_o   (text_done)
  );

  dead_key_accent_composer_checker i_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .text_byte_i         (text_byte),
    .end_of_text_i       (end_of_text),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .code_point_i        (code_point),
    .last_of_run_i       (last_of_run),
    .text_done_i         (text_done),
    .fail_count_o        (fail_count),
    .chars_outstanding_o (chars_outstanding)
  );

  // Returns at the clock edge where the byte transfer takes place.
  task automatic put_byte(input logic [7:0] b, input logic eot);
    while (!quiet && ($urandom_range(99) < 21)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Encodes cp in len bytes, overlong forms allowed, and sends the first keep of them.
  task automatic send_char(input logic [20:0] cp, input int len, input int keep,
                           input logic eot);
    logic [7:0] seq [4];
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int k = 0; k < keep; k++) begin
      put_byte(seq[k], eot && (k == keep - 1));
    end
  endtask

  task automatic send_dead_key(input logic eot);
    logic [20:0] accents [4];
    int          len;
    accents = '{CP_ACUTE, CP_GRAVE, CP_CIRC, CP_DIAER};
    len     = $urandom_range(2, 3);
    case ($urandom_range(5))
      0: send_char(CP_GRAVE, 1, 1, eot);
      1: send_char(CP_CIRC, 1, 1, eot);
      2: send_char(CP_ACUTE, 2, 2, eot);
      3: send_char(CP_DIAER, 2, 2, eot);
      // A bare byte 0xB4 or 0xA8 is a stray continuation byte and still acts as an accent.
      4: put_byte($urandom_range(1) ? CP_ACUTE[7:0] : CP_DIAER[7:0], eot);
      default: send_char(accents[$urandom_range(3)], len, len, eot);
    endcase
  endtask

  task automatic send_random_char();
    logic        eot;
    int          pick;
    int          len;
    int          bits;
    logic [20:0] cp;
    eot  = ($urandom_range(99) < 6);
    pick = $urandom_range(99);
    len  = $urandom_range(2, 4);
    bits = (len == 2) ? 11 : (len == 3) ? 16 : 21;
    cp   = 21'($urandom() & ((32'd1 << bits) - 1));
    if (pick < 30) begin
      send_char({13'h0, VOWEL_TEXT[8*$urandom_range(11) +: 8]}, 1, 1, eot);
    end else if (pick < 50) begin
      send_dead_key(eot);
    end else if (pick < 63) begin
      put_byte(8'($urandom_range(127)), eot);
    end else if (pick < 78) begin
      send_char(cp, len, len, eot);
    end else if (pick < 82) begin
      // Overlong vowel still decodes to the vowel.
      send_char({13'h0, VOWEL_TEXT[8*$urandom_range(11) +: 8]}, len, len, eot);
    end else if (pick < 90) begin
      send_char(cp, len, $urandom_range(1, len - 1), eot);
    end else begin
      put_byte(8'($urandom_range(255)), eot);
    end
  endtask

  // Receiver side.
  initial begin
    logic hold_taken;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 21);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic held_once;
    logic paused_once;
    held_once   = 1'b0;
    paused_once = 1'b0;
    bytes_sent  = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    text_byte   <= 8'h00;
    end_of_text <= 1'b0;
    hold_req    <= 1'b0;
    quiet       <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < 23; k++) begin
      put_byte(OPENING_TEXT[k][7:0], OPENING_TEXT[k][8]);
    end

    while (bytes_sent < 23 + RANDOM_BYTES) begin
      if (!held_once && (bytes_sent >= 200)) begin
        // Receiver holds off while bytes keep coming, so the input backs up.
        held_once = 1'b1;
        hold_req <= 1'b1;
      end
      if (!paused_once && (bytes_sent >= 400)) begin
        paused_once = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (chars_outstanding == 0);
        @(posedge clk);
      end
      quiet <= (bytes_sent >= 450) && (bytes_sent < 560);
      send_random_char();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait (chars_outstanding == 0);
    repeat (10) @(posedge clk);
    if ((fail_count == 0) && (chars_outstanding == 0)) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
